[hdl/skperm_pkg.sv]
// Shared types, constants and helpers for the sorted k-permutation enumerator.
package skperm_pkg;

    localparam int MAX_VALUES   = 8;
    localparam int VALUE_BITS   = 16;
    localparam int RESULT_LIMIT = 8;
    localparam int IDX_W        = (MAX_VALUES > 1) ? $clog2(MAX_VALUES) : 1;
    localparam int CNT_W        = $clog2(MAX_VALUES + 1);
    localparam int PICK_W       = 4;

    typedef enum logic [1:0] {
        MODE_CLEAR = 2'd0,
        MODE_LOAD  = 2'd1,
        MODE_NEXT  = 2'd2,
        MODE_NONE  = 2'd3
    } mode_t;

    typedef struct packed {
        logic [1:0]            mode;
        logic [VALUE_BITS-1:0] value;
    } req_t;

    typedef struct packed {
        logic [VALUE_BITS-1:0] element;
        logic                  last_of_sequence;
        logic                  exhausted;
        logic                  overflow;
    } rsp_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ADV,
        ST_FILL,
        ST_EMIT,
        ST_FLAG
    } state_t;

    // Controller to datapath
    typedef struct packed {
        logic clear;     // empty store, restart
        logic load;      // sorted insert, restart
        logic cfg_wr;    // new pick count, restart
        logic first;     // first pick: positions 0..k-1
        logic resume;    // start backtrack at level k-1
        logic adv;       // one backtrack step at current level
        logic fill;      // fill current level with smallest free index
        logic emit;      // load result reg with element at current level
        logic flag;      // load result reg with a flag item
        logic flag_ovf;  // flag item is overflow (else exhausted)
    } cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic full;      // store holds MAX_VALUES entries
        logic bad;       // next request must give exhausted
        logic started;
        logic found;     // a larger free index exists at this level
        logic lvl_top;   // level == pick_count-1
        logic lvl_bot;   // level == 0
    } sts_t;

    // Index of the lowest set bit (0 when none).
    function automatic logic [IDX_W-1:0] lowest_set(input logic [MAX_VALUES-1:0] v);
        logic [IDX_W-1:0] r;
        r = '0;
        for (int i = MAX_VALUES - 1; i >= 0; i--) begin
            if (v[i]) begin
                r = IDX_W'(i);
            end
        end
        return r;
    endfunction

endpackage

[hdl/skperm_dp.sv]
// Datapath: sorted store, index stack, used mask and result register.
module skperm_dp (
    input  logic                          clk,
    input  logic                          rst_n,
    input  skperm_pkg::cmd_t              cmd,
    input  skperm_pkg::req_t              req,
    input  logic [skperm_pkg::PICK_W-1:0] cfg_data,
    output skperm_pkg::sts_t              sts,
    output skperm_pkg::rsp_t              rsp
);

    logic [skperm_pkg::VALUE_BITS-1:0] vals_reg  [skperm_pkg::MAX_VALUES];
    logic [skperm_pkg::IDX_W-1:0]      stack_reg [skperm_pkg::MAX_VALUES];
    logic [skperm_pkg::CNT_W-1:0]      cnt_reg;
    logic [skperm_pkg::MAX_VALUES-1:0] mask_reg;
    logic                              started_reg;
    logic                              done_reg;
    logic [skperm_pkg::PICK_W-1:0]     pick_reg;
    logic [skperm_pkg::IDX_W-1:0]      lvl_reg;
    skperm_pkg::rsp_t                  rsp_reg;

    logic [skperm_pkg::MAX_VALUES-1:0] n_mask;
    logic [skperm_pkg::MAX_VALUES-1:0] free_mask;
    logic [skperm_pkg::MAX_VALUES-1:0] cand_mask;
    logic [skperm_pkg::MAX_VALUES-1:0] gt;
    logic [skperm_pkg::MAX_VALUES-1:0] first_mask;
    logic [skperm_pkg::IDX_W-1:0]      cur_idx;
    logic [skperm_pkg::IDX_W-1:0]      cand_idx;
    logic [skperm_pkg::IDX_W-1:0]      fill_idx;
    logic                              lvl_top;
    logic                              lvl_bot;
    logic                              found;

    assign cur_idx = stack_reg[lvl_reg];

    always_comb
    begin
        for (int j = 0; j < skperm_pkg::MAX_VALUES; j++) begin
            n_mask[j]     = (32'(j) < 32'(cnt_reg));
            cand_mask[j]  = (32'(j) > 32'(cur_idx));
            gt[j]         = n_mask[j] && (vals_reg[j] > req.value);
            first_mask[j] = (32'(j) < 32'(pick_reg));
        end
        free_mask = ~mask_reg & n_mask;
        cand_mask = cand_mask & free_mask;
    end

    assign found    = |cand_mask;
    assign cand_idx = skperm_pkg::lowest_set(cand_mask);
    assign fill_idx = skperm_pkg::lowest_set(free_mask);
    assign lvl_top  = (32'(lvl_reg) + 32'd1 == 32'(pick_reg));
    assign lvl_bot  = (lvl_reg == '0);

    always_comb
    begin
        sts.full    = (32'(cnt_reg) >= skperm_pkg::MAX_VALUES);
        sts.bad     = (pick_reg == '0) || (32'(pick_reg) > 32'(cnt_reg)) ||
                      (32'(pick_reg) > skperm_pkg::RESULT_LIMIT) || done_reg;
        sts.started = started_reg;
        sts.found   = found;
        sts.lvl_top = lvl_top;
        sts.lvl_bot = lvl_bot;
    end

    // Enumeration control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            cnt_reg     <= '0;
            mask_reg    <= '0;
            started_reg <= 1'b0;
            done_reg    <= 1'b0;
            pick_reg    <= skperm_pkg::PICK_W'(1);
            lvl_reg     <= '0;
            for (int p = 0; p < skperm_pkg::MAX_VALUES; p++) begin
                stack_reg[p] <= '0;
            end
        end else begin
            if (cmd.clear || cmd.load || cmd.cfg_wr) begin
                mask_reg    <= '0;
                started_reg <= 1'b0;
                done_reg    <= 1'b0;
            end
            if (cmd.clear) begin
                cnt_reg <= '0;
            end
            if (cmd.load) begin
                cnt_reg <= cnt_reg + skperm_pkg::CNT_W'(1);
            end
            if (cmd.cfg_wr) begin
                pick_reg <= cfg_data;
            end
            if (cmd.first) begin
                for (int p = 0; p < skperm_pkg::MAX_VALUES; p++) begin
                    stack_reg[p] <= skperm_pkg::IDX_W'(p);
                end
                mask_reg    <= first_mask;
                started_reg <= 1'b1;
                lvl_reg     <= '0;
            end
            if (cmd.resume) begin
                lvl_reg <= skperm_pkg::IDX_W'(pick_reg - skperm_pkg::PICK_W'(1));
            end
            if (cmd.adv) begin
                if (found) begin
                    stack_reg[lvl_reg] <= cand_idx;
                    mask_reg <= (mask_reg & ~(skperm_pkg::MAX_VALUES'(1) << cur_idx))
                              | (skperm_pkg::MAX_VALUES'(1) << cand_idx);
                    lvl_reg  <= lvl_top ? '0 : lvl_reg + skperm_pkg::IDX_W'(1);
                end else if (lvl_bot) begin
                    // nothing left at the root: enumeration over
                    mask_reg <= '0;
                    done_reg <= 1'b1;
                end else begin
                    mask_reg <= mask_reg & ~(skperm_pkg::MAX_VALUES'(1) << cur_idx);
                    lvl_reg  <= lvl_reg - skperm_pkg::IDX_W'(1);
                end
            end
            if (cmd.fill) begin
                stack_reg[lvl_reg] <= fill_idx;
                mask_reg <= mask_reg | (skperm_pkg::MAX_VALUES'(1) << fill_idx);
                lvl_reg  <= lvl_top ? '0 : lvl_reg + skperm_pkg::IDX_W'(1);
            end
            if (cmd.emit) begin
                lvl_reg <= lvl_reg + skperm_pkg::IDX_W'(1);
            end
        end
    end

    // Sorted insert: entries above the slot move up by one
    always_ff @(posedge clk)
    begin
        if (cmd.load) begin
            for (int p = 0; p < skperm_pkg::MAX_VALUES; p++) begin
                if (p > 0 && gt[(p > 0) ? p - 1 : 0]) begin
                    vals_reg[p] <= vals_reg[(p > 0) ? p - 1 : 0];
                end else if (gt[p] || (32'(p) == 32'(cnt_reg))) begin
                    vals_reg[p] <= req.value;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.emit) begin
            rsp_reg.element          <= vals_reg[cur_idx];
            rsp_reg.last_of_sequence <= lvl_top;
            rsp_reg.exhausted        <= 1'b0;
            rsp_reg.overflow         <= 1'b0;
        end else if (cmd.flag) begin
            rsp_reg.element          <= '0;
            rsp_reg.last_of_sequence <= !cmd.flag_ovf;
            rsp_reg.exhausted        <= !cmd.flag_ovf;
            rsp_reg.overflow         <= cmd.flag_ovf;
        end
    end

    assign rsp = rsp_reg;

endmodule

[hdl/skperm_ctrl.sv]
// Controller: request decode, backtrack sequencing and result handshake.
module skperm_ctrl (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             req_valid,
    input  logic [1:0]       req_mode,
    input  logic             cfg_valid,
    input  logic             rsp_ready,
    input  skperm_pkg::sts_t sts,
    output logic             req_ready,
    output logic             cfg_ready,
    output logic             rsp_valid,
    output skperm_pkg::cmd_t cmd
);

    skperm_pkg::state_t state_reg, state_next;
    logic               rsp_valid_reg, rsp_valid_next;
    logic               flag_ovf_reg, flag_ovf_next;
    logic               out_free;
    logic               accept;

    assign out_free = !rsp_valid_reg || rsp_ready;
    assign accept   = req_valid && (state_reg == skperm_pkg::ST_IDLE) && !cfg_valid;

    // Next state
    always_comb
    begin
        state_next    = state_reg;
        flag_ovf_next = flag_ovf_reg;
        case (state_reg)
            skperm_pkg::ST_IDLE:
            begin
                if (accept) begin
                    flag_ovf_next = (req_mode == skperm_pkg::MODE_LOAD);
                    case (req_mode)
                        skperm_pkg::MODE_LOAD:
                        begin
                            if (sts.full) begin
                                state_next = skperm_pkg::ST_FLAG;
                            end
                        end
                        skperm_pkg::MODE_NEXT:
                        begin
                            if (sts.bad) begin
                                state_next = skperm_pkg::ST_FLAG;
                            end else if (sts.started) begin
                                state_next = skperm_pkg::ST_ADV;
                            end else begin
                                state_next = skperm_pkg::ST_EMIT;
                            end
                        end
                        default:
                        begin
                            state_next = skperm_pkg::ST_IDLE;
                        end
                    endcase
                end
            end
            skperm_pkg::ST_ADV:
            begin
                if (sts.found) begin
                    state_next = sts.lvl_top ? skperm_pkg::ST_EMIT : skperm_pkg::ST_FILL;
                end else if (sts.lvl_bot) begin
                    state_next = skperm_pkg::ST_FLAG;
                end
            end
            skperm_pkg::ST_FILL:
            begin
                if (sts.lvl_top) begin
                    state_next = skperm_pkg::ST_EMIT;
                end
            end
            skperm_pkg::ST_EMIT:
            begin
                if (out_free && sts.lvl_top) begin
                    state_next = skperm_pkg::ST_IDLE;
                end
            end
            skperm_pkg::ST_FLAG:
            begin
                if (out_free) begin
                    state_next = skperm_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = skperm_pkg::ST_IDLE;
            end
        endcase

        if (cmd.emit || cmd.flag) begin
            rsp_valid_next = 1'b1;
        end else if (rsp_ready) begin
            rsp_valid_next = 1'b0;
        end else begin
            rsp_valid_next = rsp_valid_reg;
        end
    end

    // Outputs
    always_comb
    begin
        req_ready    = (state_reg == skperm_pkg::ST_IDLE) && !cfg_valid;
        cfg_ready    = (state_reg == skperm_pkg::ST_IDLE);
        rsp_valid    = rsp_valid_reg;
        cmd          = '0;
        cmd.cfg_wr   = cfg_valid && (state_reg == skperm_pkg::ST_IDLE);
        cmd.clear    = accept && (req_mode == skperm_pkg::MODE_CLEAR);
        cmd.load     = accept && (req_mode == skperm_pkg::MODE_LOAD) && !sts.full;
        cmd.first    = accept && (req_mode == skperm_pkg::MODE_NEXT) && !sts.bad
                       && !sts.started;
        cmd.resume   = accept && (req_mode == skperm_pkg::MODE_NEXT) && !sts.bad
                       && sts.started;
        cmd.adv      = (state_reg == skperm_pkg::ST_ADV);
        cmd.fill     = (state_reg == skperm_pkg::ST_FILL);
        cmd.emit     = (state_reg == skperm_pkg::ST_EMIT) && out_free;
        cmd.flag     = (state_reg == skperm_pkg::ST_FLAG) && out_free;
        cmd.flag_ovf = flag_ovf_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            state_reg     <= skperm_pkg::ST_IDLE;
            rsp_valid_reg <= 1'b0;
            flag_ovf_reg  <= 1'b0;
        end else begin
            state_reg     <= state_next;
            rsp_valid_reg <= rsp_valid_next;
            flag_ovf_reg  <= flag_ovf_next;
        end
    end

endmodule

[hdl/sorted_k_permutation_enumerator.sv]
// Top level of the sorted k-permutation enumerator.
// The block keeps up to eight 16-bit values in ascending order (a load places
// the value after any equal ones) and, on each "next" request, returns the next
// ordered pick of pick_count distinct store positions in lexicographic order of
// position indices, one element per result item with last_of_sequence on the
// final one. A request with pick_count of zero or above the loaded count, or
// one after the last pick, gives a single exhausted item; a load into a full
// store gives a single overflow item. Clear, load and any write of pick_count
// restart the enumeration. The first pick after a restart goes straight to the
// emit steps; a later pick first runs the backtrack sequencer one stack level
// per cycle (levels popped until a larger free index is found, then the deeper
// levels refilled) before the emit steps, one per element of the pick. Emit
// steps wait while the result register is held by the consumer. One request is
// worked on at a time; req_ready and cfg_ready are high only while the
// sequencer is idle, and a configuration write takes precedence over a request
// in the same cycle.
module sorted_k_permutation_enumerator (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          req_valid,
    output logic                          req_ready,
    input  skperm_pkg::req_t              req,
    output logic                          rsp_valid,
    input  logic                          rsp_ready,
    output skperm_pkg::rsp_t              rsp,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [skperm_pkg::PICK_W-1:0] cfg_data
);

    skperm_pkg::cmd_t cmd;
    skperm_pkg::sts_t sts;

    // Sequencer: decodes requests, steps the backtrack, owns rsp_valid
    skperm_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_mode  (req.mode),
        .cfg_valid (cfg_valid),
        .rsp_ready (rsp_ready),
        .sts       (sts),
        .req_ready (req_ready),
        .cfg_ready (cfg_ready),
        .rsp_valid (rsp_valid),
        .cmd       (cmd)
    );

    // Store, index stack, used mask and the result register
    skperm_dp u_dp (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd      (cmd),
        .req      (req),
        .cfg_data (cfg_data),
        .sts      (sts),
        .rsp      (rsp)
    );

endmodule

[hdl/skperm_chk.sv]
// Port-level checks for the enumerator, bound to the top level.
module skperm_chk (
    input logic                          clk,
    input logic                          rst_n,
    input logic                          req_valid,
    input logic                          req_ready,
    input skperm_pkg::req_t              req,
    input logic                          rsp_valid,
    input logic                          rsp_ready,
    input skperm_pkg::rsp_t              rsp,
    input logic                          cfg_valid,
    input logic                          cfg_ready,
    input logic [skperm_pkg::PICK_W-1:0] cfg_data
);

    // a stalled result item holds
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp))
        else $error("result item changed while stalled");

    // exhausted item: last set, element zero, no overflow
    a_exh_shape: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp.exhausted |-> rsp.last_of_sequence && rsp.element == '0
        && !rsp.overflow)
        else $error("malformed exhausted item");

    // overflow item carries nothing else
    a_ovf_shape: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp.overflow |-> !rsp.last_of_sequence && !rsp.exhausted
        && rsp.element == '0)
        else $error("malformed overflow item");

    // config write and request never land in the same cycle
    a_cfg_req_excl: assert property (@(posedge clk) disable iff (!rst_n)
        !(cfg_valid && cfg_ready && req_valid && req_ready))
        else $error("config write and request accepted together");

    // after a clear is taken the block is idle again in the next cycle
    a_clear_idle: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_ready && req.mode == skperm_pkg::MODE_CLEAR |=> cfg_ready)
        else $error("clear did not return to idle");

endmodule

bind sorted_k_permutation_enumerator skperm_chk u_skperm_chk (
    .clk       (clk),
    .rst_n     (rst_n),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp       (rsp),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
);

[verif/skperm_check.sv]
// Checker for the sorted k-permutation enumerator: tracks the store and pick walk, compares result items.
module skperm_check (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          req_valid,
    input  logic                          req_ready,
    input  skperm_pkg::req_t              req,
    input  logic                          rsp_valid,
    input  logic                          rsp_ready,
    input  skperm_pkg::rsp_t              rsp,
    input  logic                          cfg_valid,
    input  logic                          cfg_ready,
    input  logic [skperm_pkg::PICK_W-1:0] cfg_data,
    output int unsigned                   fail_count,
    output int unsigned                   pending
);
    import skperm_pkg::*;

    logic [VALUE_BITS-1:0] store [MAX_VALUES];
    int                    held;
    int                    stack_pos [MAX_VALUES];
    logic [MAX_VALUES-1:0] taken;
    bit                    begun;
    bit                    finished;
    logic [PICK_W-1:0]     pick;
    rsp_t                  pick_q [$];

    task automatic report(input string field, input logic [31:0] got,
                          input logic [31:0] want);
        $display("%0t mismatch on %s: got %h, expected %h", $time, field, got, want);
        fail_count++;
    endtask

    // Append one predicted item at the tail.
    function automatic void add_want(input rsp_t r);
        pick_q = {pick_q, r};
    endfunction

    function automatic void restart_walk();
        for (int p = 0; p < MAX_VALUES; p++)
            stack_pos[p] = 0;
        taken    = '0;
        begun    = 1'b0;
        finished = 1'b0;
    endfunction

    // Positions from..k-1 take the smallest free store indexes.
    function automatic void fill_lowest(input int from, input int k);
        bit hit;
        for (int p = from; p < k; p++) begin
            hit = 1'b0;
            for (int j = 0; j < held; j++) begin
                if (!hit && !taken[j]) begin
                    stack_pos[p] = j;
                    taken[j]     = 1'b1;
                    hit          = 1'b1;
                end
            end
        end
    endfunction

    // Backtrack to the next pick in lexicographic order; 0 when none is left.
    function automatic bit step_walk(input int k);
        for (int i = k - 1; i >= 0; i--) begin
            taken[stack_pos[i]] = 1'b0;
            for (int j = stack_pos[i] + 1; j < held; j++) begin
                if (!taken[j]) begin
                    stack_pos[i] = j;
                    taken[j]     = 1'b1;
                    fill_lowest(i + 1, k);
                    return 1'b1;
                end
            end
        end
        return 1'b0;
    endfunction

    task automatic enumerate_step(input req_t item);
        int   k;
        int   pos;
        rsp_t r;
        k = int'(pick);
        r = '0;
        case (item.mode)
            MODE_CLEAR:
            begin
                for (int p = 0; p < MAX_VALUES; p++)
                    store[p] = '0;
                held = 0;
                restart_walk();
            end
            MODE_LOAD:
            begin
                if (held >= MAX_VALUES) begin
                    r.overflow = 1'b1;
                    add_want(r);
                end
                else begin
                    // insert after any equal value
                    pos = held;
                    while (pos > 0 && store[pos-1] > item.value) begin
                        store[pos] = store[pos-1];
                        pos--;
                    end
                    store[pos] = item.value;
                    held++;
                    restart_walk();
                end
            end
            MODE_NEXT:
            begin
                r.last_of_sequence = 1'b1;
                r.exhausted        = 1'b1;
                if (k == 0 || k > held || k > RESULT_LIMIT || finished) begin
                    add_want(r);
                end
                else if (begun && !step_walk(k)) begin
                    finished = 1'b1;
                    taken    = '0;
                    add_want(r);
                end
                else begin
                    if (!begun) begin
                        taken = '0;
                        fill_lowest(0, k);
                        begun = 1'b1;
                    end
                    for (int p = 0; p < k; p++) begin
                        r.element          = store[stack_pos[p]];
                        r.last_of_sequence = (p == k - 1);
                        r.exhausted        = 1'b0;
                        add_want(r);
                    end
                end
            end
            default:
            begin
            end
        endcase
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        rsp_t want;
        if (!rst_n) begin
            for (int p = 0; p < MAX_VALUES; p++)
                store[p] = '0;
            held       = 0;
            pick       = PICK_W'(1);
            restart_walk();
            pick_q.delete();
            fail_count = 0;
            pending   <= 0;
        end
        else begin
            if (rsp_valid && rsp_ready) begin
                if (pick_q.size() == 0) begin
                    report("item with nothing expected", 32'(rsp), 32'd0);
                end
                else begin
                    want = pick_q.pop_front();
                    if (rsp.element !== want.element)
                        report("element", 32'(rsp.element), 32'(want.element));
                    if (rsp.last_of_sequence !== want.last_of_sequence)
                        report("last_of_sequence", 32'(rsp.last_of_sequence),
                               32'(want.last_of_sequence));
                    if (rsp.exhausted !== want.exhausted)
                        report("exhausted", 32'(rsp.exhausted), 32'(want.exhausted));
                    if (rsp.overflow !== want.overflow)
                        report("overflow", 32'(rsp.overflow), 32'(want.overflow));
                end
            end
            if (cfg_valid && cfg_ready) begin
                pick = cfg_data;
                restart_walk();
            end
            if (req_valid && req_ready)
                enumerate_step(req);
            pending <= pick_q.size();
        end
    end

endmodule

[verif/testbench.sv]
// Top of the enumerator testbench: clock, reset, stimulus, receiver stalls and verdict.
module testbench;
    import skperm_pkg::*;

    // Stimulus stops once this many non-ignored items have gone in.
    localparam int ITEM_TARGET  = 460;
    // Slack before going idle, enough for the slowest request to finish.
    localparam int DRAIN_CYCLES = 32;
    // Watchdog limit, well above a worst case of 460 items with up to eight
    // results each and every result held by a long stall.
    localparam int CYCLE_LIMIT  = 500000;

    logic              clk       = 1'b0;
    logic              rst_n     = 1'b0;
    logic              req_valid = 1'b0;
    req_t              req       = '0;
    logic              rsp_ready = 1'b0;
    logic              cfg_valid = 1'b0;
    logic [PICK_W-1:0] cfg_data  = '0;
    logic              req_ready;
    logic              rsp_valid;
    rsp_t              rsp;
    logic              cfg_ready;
    int unsigned       fail_count;
    int unsigned       pending;

    int unsigned burst_left   = 0;   // items left in the current sender burst
    int unsigned items_sent   = 0;
    int unsigned cycles       = 0;
    int unsigned window_left  = 0;   // cycles left in the current receiver window
    int unsigned window_style = 0;
    int unsigned tick         = 0;

    sorted_k_permutation_enumerator u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp       (rsp),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    skperm_check u_chk (
        .clk        (clk),
        .rst_n      (rst_n),
        .req_valid  (req_valid),
        .req_ready  (req_ready),
        .req        (req),
        .rsp_valid  (rsp_valid),
        .rsp_ready  (rsp_ready),
        .rsp        (rsp),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_data   (cfg_data),
        .fail_count (fail_count),
        .pending    (pending)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // Watchdog: a hang or a missing result ends up here.
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    // Receiver backpressure: windows of random length, each with its own style:
    // always ready, mostly ready, mostly stalled, or a periodic duty pattern that
    // is mostly stalled.
    always @(posedge clk)
    begin
        tick <= tick + 1;
        if (window_left == 0) begin
            window_style <= $urandom_range(0, 3);
            window_left  <= $urandom_range(16, 96);
        end
        else begin
            window_left <= window_left - 1;
        end
        case (window_style)
            0:       rsp_ready <= 1'b1;
            1:       rsp_ready <= ($urandom_range(0, 3) != 0);
            2:       rsp_ready <= ($urandom_range(0, 3) == 0);
            default: rsp_ready <= ((tick % 11) >= 7);
        endcase
    end

    // Sender: items go out in bursts of 1..12, sometimes with idle cycles between
    // bursts and sometimes with none, which keeps valid high across the boundary.
    task automatic send_req(input logic [1:0] mode, input logic [VALUE_BITS-1:0] value);
        int   gap;
        req_t item;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0) begin
                req_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst_left = $urandom_range(1, 12);
        end
        item.mode  = mode;
        item.value = value;
        req_valid <= 1'b1;
        req       <= item;
        do
            @(posedge clk);
        while (!req_ready);
        burst_left--;
        if (mode != MODE_NONE)
            items_sent++;
    endtask

    // Quiesce: stop sending, wait for every predicted item to come back, then
    // let a load or clear still in flight finish before touching the register.
    task automatic settle();
        req_valid <= 1'b0;
        burst_left = 0;
        do
            @(posedge clk);
        while (pending != 0);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_pick(input logic [PICK_W-1:0] k);
        cfg_valid <= 1'b1;
        cfg_data  <= k;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
    endtask

    initial
    begin
        int                    phase;
        int                    kk;
        int                    sel;
        int                    n_load;
        int                    n_next;
        int                    perms;
        int                    vsel;
        int                    noise;
        logic [VALUE_BITS-1:0] v;

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part, pick_count at its reset value of one.
        send_req(MODE_NEXT, 16'h0000);      // empty store: exhausted
        send_req(MODE_NONE, 16'hFFFF);      // ignored mode
        send_req(MODE_LOAD, 16'hFFFF);
        send_req(MODE_LOAD, 16'h0000);
        send_req(MODE_LOAD, 16'h1234);
        send_req(MODE_LOAD, 16'h1234);      // duplicate lands after its twin
        send_req(MODE_LOAD, 16'hAAAA);
        send_req(MODE_LOAD, 16'h5555);
        send_req(MODE_LOAD, 16'h0001);
        send_req(MODE_LOAD, 16'hFFFE);      // store now full
        send_req(MODE_LOAD, 16'h7777);      // overflow
        repeat (9) send_req(MODE_NEXT, 16'hFFFF);  // all eight, then exhausted
        send_req(MODE_NEXT, 16'h0000);      // stays exhausted
        send_req(MODE_CLEAR, 16'hFFFF);
        send_req(MODE_NEXT, 16'h0000);      // cleared store: exhausted
        settle();

        // Random phases: register write, usually a clear, a run of loads, then
        // enough next requests to walk the whole enumeration when it is short.
        // The first three phases pin the register extremes: above eight, zero
        // and eight.
        phase = 0;
        while (items_sent < ITEM_TARGET) begin
            case (phase)
                0: kk = 15;
                1: kk = 0;
                2: kk = 8;
                default:
                begin
                    sel = $urandom_range(0, 19);
                    if (sel == 0)
                        kk = 0;
                    else if (sel == 1)
                        kk = 8;
                    else if (sel == 2)
                        kk = $urandom_range(9, 15);
                    else
                        kk = $urandom_range(1, 4);
                end
            endcase
            write_pick(PICK_W'(kk));

            if (phase == 2)
                n_load = 8;
            else if ($urandom_range(0, 9) == 0)
                n_load = $urandom_range(8, 10);   // fills the store, often running into overflow
            else
                n_load = $urandom_range(0, 5);

            // narrow range makes duplicates, the third style hits the extremes
            vsel = $urandom_range(0, 2);
            if ($urandom_range(0, 5) != 0)
                send_req(MODE_CLEAR, VALUE_BITS'($urandom));
            for (int i = 0; i < n_load; i++) begin
                if (vsel == 0)
                    v = VALUE_BITS'($urandom_range(0, 3));
                else if (vsel == 1)
                    v = VALUE_BITS'($urandom_range(0, 65535));
                else
                    v = $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
                send_req(MODE_LOAD, v);
            end

            // n!/(n-k)! picks; only a guide, since a skipped clear leaves old values
            perms = 0;
            if (kk > 0 && kk <= n_load && kk <= 8) begin
                perms = 1;
                for (int i = 0; i < kk; i++)
                    perms = perms * (((n_load > 8) ? 8 : n_load) - i);
            end
            if (perms == 0)
                n_next = $urandom_range(1, 3);
            else if (perms <= 24)
                n_next = perms + $urandom_range(1, 2);
            else
                n_next = $urandom_range(2, 10);

            // Occasional noise breaks the walk: ignored items, a stray load
            // that restarts it, or a clear that empties the store.
            for (int i = 0; i < n_next; i++) begin
                noise = $urandom_range(0, 15);
                if (noise == 0)
                    send_req(MODE_NONE, VALUE_BITS'($urandom));
                else if (noise == 1)
                    send_req(MODE_LOAD, VALUE_BITS'($urandom));
                else if (noise == 2 && $urandom_range(0, 3) == 0)
                    send_req(MODE_CLEAR, VALUE_BITS'($urandom));
                send_req(MODE_NEXT, VALUE_BITS'($urandom));
            end
            settle();
            phase++;
        end

        if (fail_count == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule

[sorted_k_permutation_enumerator.f]
hdl/skperm_pkg.sv
hdl/skperm_dp.sv
hdl/skperm_ctrl.sv
hdl/sorted_k_permutation_enumerator.sv
hdl/skperm_chk.sv
verif/skperm_check.sv
verif/testbench.sv
